// ----- design/vlc_pkg.sv -----
// Shared types, constants and letter tables for the Vigenere letter cipher.
// No dependencies; imported by the core, the key RAM user and the checker.
`default_nettype none

package vlc_pkg;

  localparam int unsigned KeyMax = 64;
  localparam int unsigned KeyAw  = (KeyMax > 1) ? $clog2(KeyMax) : 1;
  localparam int unsigned KeyCw  = $clog2(KeyMax + 1);
  localparam int unsigned CpW    = 9;
  localparam int unsigned CodeW  = 6;

  typedef logic [CpW-1:0]   cp_t;
  typedef logic [CodeW-1:0] code_t;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_MESSAGE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LETTER   = 3'd0,
    ST_MSG_SKIP = 3'd1,
    ST_NO_KEY   = 3'd2,
    ST_DONE     = 3'd3,
    ST_KEY_SKIP = 3'd4,
    ST_KEY_FULL = 3'd5
  } status_e;

  // configuration register indexes
  localparam logic CfgPolish  = 1'b0;
  localparam logic CfgEncrypt = 1'b1;

  localparam code_t PolLen    = 6'd35;
  localparam code_t LatLen    = 6'd26;
  localparam code_t OtherCode = 6'd35;
  localparam cp_t   LatA      = 9'h041;

  localparam cp_t PolCp [35] = '{
    9'h041, 9'h104, 9'h042, 9'h043, 9'h106, 9'h044, 9'h045, 9'h118, 9'h046,
    9'h047, 9'h048, 9'h049, 9'h04A, 9'h04B, 9'h04C, 9'h141, 9'h04D, 9'h04E,
    9'h143, 9'h04F, 9'h0D3, 9'h050, 9'h051, 9'h052, 9'h053, 9'h15A, 9'h054,
    9'h055, 9'h056, 9'h057, 9'h058, 9'h059, 9'h05A, 9'h179, 9'h17B
  };

  localparam logic [4:0] LatBase [35] = '{
    5'd0, 5'd0, 5'd1, 5'd2, 5'd2, 5'd3, 5'd4, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
    5'd9, 5'd10, 5'd11, 5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
    5'd16, 5'd17, 5'd18, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24,
    5'd25, 5'd25, 5'd25
  };

  localparam logic IsDiac [35] = '{
    1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1
  };

  // Polish position of each plain letter A..Z
  localparam code_t LatPos [26] = '{
    6'd0, 6'd2, 6'd3, 6'd5, 6'd6, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13,
    6'd14, 6'd16, 6'd17, 6'd19, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32
  };

  function automatic logic is_letter(cp_t c);
    logic r;
    r = 1'b0;
    if ((c >= 9'h041 && c <= 9'h05A) || (c >= 9'h061 && c <= 9'h07A)) r = 1'b1;
    else if (c == 9'h0AA || c == 9'h0B5 || c == 9'h0BA) r = 1'b1;
    else if (c >= 9'h0C0 && c <= 9'h0FF) r = (c != 9'h0D7) && (c != 9'h0F7);
    else if (c >= 9'h100 && c <= 9'h17F) r = 1'b1;
    return r;
  endfunction

  function automatic cp_t fold_upper(cp_t c);
    cp_t r;
    r = c;
    if (c >= 9'h061 && c <= 9'h07A) r = c - 9'h020;
    else if (c >= 9'h0E0 && c <= 9'h0FE && c != 9'h0F7) r = c - 9'h020;
    else if (c >= 9'h100 && c <= 9'h137) r = {c[8:1], 1'b0};
    else if (c >= 9'h139 && c <= 9'h148) r = c[0] ? c : c - 9'h001;
    else if (c >= 9'h14A && c <= 9'h177) r = {c[8:1], 1'b0};
    else if (c >= 9'h179 && c <= 9'h17E) r = c[0] ? c : c - 9'h001;
    else if (c == 9'h17F) r = 9'h053;
    return r;
  endfunction

  function automatic code_t letter_code(cp_t c);
    cp_t   u;
    cp_t   off;
    code_t r;
    u   = fold_upper(c);
    off = u - LatA;
    r   = OtherCode;
    if (u >= 9'h041 && u <= 9'h05A) begin
      r = LatPos[off[4:0]];
    end else begin
      case (u)
        9'h104:  r = 6'd1;
        9'h106:  r = 6'd4;
        9'h118:  r = 6'd7;
        9'h141:  r = 6'd15;
        9'h143:  r = 6'd18;
        9'h0D3:  r = 6'd20;
        9'h15A:  r = 6'd25;
        9'h179:  r = 6'd33;
        9'h17B:  r = 6'd34;
        default: r = OtherCode;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/vlc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the key letter codes for the cipher core.
`default_nettype none

module vlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/vigenere_letter_cipher_core.sv -----
// Top level of the Vigenere letter cipher: command decode, key bookkeeping,
// key RAM read and the modular shift. Depends on vlc_pkg and vlc_ram.
//
//   channel   direction  tdata                 tuser
//   s_axis    in         [8:0] code_point      [1:0] cmd
//   m_axis    out        [8:0] out_code        [2:0] status
//   cfg       in         cfg_index_i 0 polish_mode, 1 encrypt_mode (no handshake)
//
// One item per cycle unless m_axis stalls; an accepted item passes the s1 stage and
// the output register to m_axis. The key RAM read issued at accept is registered.
// A key append writes the RAM at accept, so the next item already reads it.
// Reset clears key count, key position and the pipeline; key RAM contents
// stay undefined until written. A stalled output holds the stage behind it.
`default_nettype none

module vigenere_letter_cipher_core
  import vlc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [8:0] code_point
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [8:0] out_code
  output logic      [2:0]  m_axis_tuser,   // [2:0] status
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic        cfg_data_i
);

  logic polish_q, encrypt_q;

  logic [KeyCw-1:0] kc_q, kc_d;
  logic [KeyAw-1:0] kp_q, kp_d;

  logic    s1_valid_q;
  status_e s1_status_q, s0_status;
  code_t   s1_mcode_q;

  logic    out_valid_q;
  status_e out_status_q;
  cp_t     out_code_q;

  logic       accept, out_free;
  cmd_e       cmd;
  cp_t        cp;
  logic       letter;
  logic       ram_we, ram_re;
  logic [KeyAw-1:0] pos_eff, pos_nxt;
  logic [KeyCw-1:0] nxt_ext;
  code_t      key_code;

  code_t      m_pos, k_pos, len;
  logic [6:0] sum, idx;
  cp_t        res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign cp     = s_axis_tdata[CpW-1:0];
  assign letter = is_letter(cp);

  assign pos_eff = (KeyCw'(kp_q) >= kc_q) ? '0 : kp_q;
  assign nxt_ext = KeyCw'(pos_eff) + KeyCw'(1);
  assign pos_nxt = (nxt_ext >= kc_q) ? '0 : pos_eff + KeyAw'(1);

  always_comb begin
    kc_d      = kc_q;
    kp_d      = kp_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    s0_status = ST_DONE;
    case (cmd)
      CMD_CLEAR: begin
        kc_d = '0;
        kp_d = '0;
      end
      CMD_APPEND: begin
        if (!letter) begin
          s0_status = ST_KEY_SKIP;
        end else if (kc_q >= KeyCw'(KeyMax)) begin
          s0_status = ST_KEY_FULL;
        end else begin
          ram_we = accept;
          kc_d   = kc_q + KeyCw'(1);
        end
      end
      CMD_RESTART: begin
        kp_d = '0;
      end
      CMD_MESSAGE: begin
        if (!letter) begin
          s0_status = ST_MSG_SKIP;
        end else if (kc_q == '0) begin
          s0_status = ST_NO_KEY;
        end else begin
          s0_status = ST_LETTER;
          ram_re    = accept;
          kp_d      = pos_nxt;
        end
      end
      default: s0_status = ST_DONE;
    endcase
  end

  vlc_ram #(
    .Width(CodeW),
    .Depth(KeyMax)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(kc_q[KeyAw-1:0]),
    .wdata_i(letter_code(cp)),
    .re_i   (ram_re),
    .raddr_i(pos_eff),
    .rdata_o(key_code)
  );

  // modular shift on the letter read back from the key RAM
  always_comb begin
    len = polish_q ? PolLen : LatLen;
    if (polish_q) begin
      m_pos = (s1_mcode_q < PolLen) ? s1_mcode_q : '0;
      k_pos = (key_code < PolLen) ? key_code : '0;
    end else begin
      m_pos = (s1_mcode_q < PolLen) ? CodeW'(LatBase[s1_mcode_q]) : '0;
      k_pos = (key_code < PolLen && !IsDiac[key_code]) ? CodeW'(LatBase[key_code]) : '0;
    end
    if (encrypt_q) sum = {1'b0, m_pos} + {1'b0, k_pos};
    else           sum = {1'b0, m_pos} + {1'b0, len} - {1'b0, k_pos};
    idx = (sum >= {1'b0, len}) ? sum - {1'b0, len} : sum;
    res = polish_q ? PolCp[idx[CodeW-1:0]] : LatA + CpW'(idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polish_q    <= 1'b0;
      encrypt_q   <= 1'b1;
      kc_q        <= '0;
      kp_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPolish) polish_q  <= cfg_data_i;
        else                          encrypt_q <= cfg_data_i;
      end
      if (accept) begin
        kc_q <= kc_d;
        kp_q <= kp_d;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= s0_status;
      s1_mcode_q  <= letter_code(cp);
    end
    if (out_free && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_code_q   <= (s1_status_q == ST_LETTER) ? res : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_code_q};

endmodule

`default_nettype wire

// ----- design/vlc_checker.sv -----
// Port-level checker for the Vigenere letter cipher core, bound to the top.
// Depends on vlc_pkg for the status codes.
`default_nettype none

module vlc_checker
  import vlc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("m_axis payload changed while stalled");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_LETTER |-> m_axis_tdata == 16'd0)
    else $error("out_code nonzero on a non-letter status");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_LETTER |->
      m_axis_tdata[8:0] >= 9'h041 && m_axis_tdata[15:9] == 7'd0)
    else $error("letter item carries no upper-case code point");

endmodule

bind vigenere_letter_cipher_core vlc_checker u_vlc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// ----- verif/vigenere_letter_cipher_core_test.sv -----
// Self-checking testbench for vigenere_letter_cipher_core: a directed table, then random
// key/message runs in each alphabet and direction; untyped items use a local predictor.
// Depends on vlc_pkg (port types, command and status codes) and the core RTL.

module vigenere_letter_cipher_core_test
  import vlc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e status;
    cp_t     code;
  } cipher_out_t;

  typedef struct packed {
    cmd_e    cmd;
    cp_t     cp;
    logic    typed;
    status_e status;
    cp_t     code;
  } stim_row_t;

  localparam int unsigned AlphaPl = 35;
  localparam int unsigned AlphaLt = 26;

  localparam int unsigned POLISH_CP [35] = '{
    'h041, 'h104, 'h042, 'h043, 'h106, 'h044, 'h045, 'h118, 'h046, 'h047, 'h048,
    'h049, 'h04A, 'h04B, 'h04C, 'h141, 'h04D, 'h04E, 'h143, 'h04F, 'h0D3, 'h050,
    'h051, 'h052, 'h053, 'h15A, 'h054, 'h055, 'h056, 'h057, 'h058, 'h059, 'h05A,
    'h179, 'h17B
  };
  localparam int unsigned PLAIN_OF [35] = '{
    0, 0, 1, 2, 2, 3, 4, 4, 5, 6, 7, 8, 9, 10, 11, 11, 12, 13, 13, 14, 14,
    15, 16, 17, 18, 18, 19, 20, 21, 22, 23, 24, 25, 25, 25
  };
  localparam bit ACCENTED [35] = '{
    0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1,
    0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1
  };

  // Latin alphabet, encrypt (reset settings)
  localparam stim_row_t DIRECTED [21] = '{
    '{CMD_MESSAGE, 9'h041, 1'b1, ST_NO_KEY,   9'h000},
    '{CMD_MESSAGE, 9'h000, 1'b1, ST_MSG_SKIP, 9'h000},
    '{CMD_MESSAGE, 9'h1FF, 1'b1, ST_MSG_SKIP, 9'h000},
    '{CMD_APPEND,  9'h0D7, 1'b1, ST_KEY_SKIP, 9'h000},
    '{CMD_APPEND,  9'h180, 1'b1, ST_KEY_SKIP, 9'h000},
    '{CMD_RESTART, 9'h17F, 1'b1, ST_DONE,     9'h000},
    '{CMD_APPEND,  9'h062, 1'b1, ST_DONE,     9'h000},
    '{CMD_APPEND,  9'h105, 1'b1, ST_DONE,     9'h000},
    '{CMD_APPEND,  9'h0E9, 1'b1, ST_DONE,     9'h000},
    '{CMD_MESSAGE, 9'h05A, 1'b1, ST_LETTER,   9'h041},
    '{CMD_MESSAGE, 9'h17A, 1'b0, ST_LETTER,   9'h000},
    '{CMD_MESSAGE, 9'h0F7, 1'b1, ST_MSG_SKIP, 9'h000},
    '{CMD_MESSAGE, 9'h17F, 1'b0, ST_LETTER,   9'h000},
    '{CMD_MESSAGE, 9'h0AA, 1'b0, ST_LETTER,   9'h000},
    '{CMD_RESTART, 9'h000, 1'b1, ST_DONE,     9'h000},
    '{CMD_MESSAGE, 9'h0D3, 1'b0, ST_LETTER,   9'h000},
    '{CMD_CLEAR,   9'h000, 1'b1, ST_DONE,     9'h000},
    '{CMD_MESSAGE, 9'h061, 1'b1, ST_NO_KEY,   9'h000},
    '{CMD_APPEND,  9'h17B, 1'b1, ST_DONE,     9'h000},
    '{CMD_MESSAGE, 9'h0B5, 1'b0, ST_LETTER,   9'h000},
    '{CMD_MESSAGE, 9'h0FF, 1'b0, ST_LETTER,   9'h000}
  };

  // {polish, encrypt} per random phase
  localparam logic [1:0] PHASE_CFG [6] = '{2'b11, 2'b10, 2'b00, 2'b01, 2'b10, 2'b11};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_CLEAR;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CfgPolish;
  logic        cfg_data_i = 1'b0;

  // typed expectation travelling with the item on the bus
  logic    given_typed = 1'b0;
  status_e given_status = ST_LETTER;
  cp_t     given_code = '0;

  // predictor state
  logic        polish_sel;
  logic        encrypt_sel;
  int unsigned key_mem [KeyMax];
  int unsigned key_len;
  int unsigned key_ptr;

  cipher_out_t cipher_q [$];
  cipher_out_t pred, head;
  int unsigned bad_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned seen_by_status [6];
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_len = 0;

  vigenere_letter_cipher_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_alpha(int unsigned c);
    if ((c >= 'h41 && c <= 'h5A) || (c >= 'h61 && c <= 'h7A)) return 1'b1;
    if (c == 'hAA || c == 'hB5 || c == 'hBA) return 1'b1;
    if (c >= 'hC0 && c <= 'hFF) return c != 'hD7 && c != 'hF7;
    return c >= 'h100 && c <= 'h17F;
  endfunction

  function automatic int unsigned to_upper(int unsigned c);
    if (c >= 'h61 && c <= 'h7A) return c - 'h20;
    if (c >= 'hE0 && c <= 'hFE && c != 'hF7) return c - 'h20;
    if (c >= 'h100 && c <= 'h137) return c & ~1;
    if (c >= 'h139 && c <= 'h148) return c[0] ? c : c - 1;
    if (c >= 'h14A && c <= 'h177) return c & ~1;
    if (c >= 'h179 && c <= 'h17E) return c[0] ? c : c - 1;
    if (c == 'h17F) return 'h53;
    return c;
  endfunction

  // position in the Polish alphabet, or AlphaPl for any other letter
  function automatic int unsigned pl_position(int unsigned c);
    int unsigned u;
    u = to_upper(c);
    for (int unsigned i = 0; i < AlphaPl; i++) begin
      if (POLISH_CP[i] == u) return i;
    end
    return AlphaPl;
  endfunction

  function automatic cipher_out_t cipher_step(cmd_e c, cp_t p);
    cipher_out_t r;
    int unsigned mc, kc, m, k, len, idx;
    r.status = ST_DONE;
    r.code   = '0;
    case (c)
      CMD_CLEAR: begin
        key_len = 0;
        key_ptr = 0;
      end
      CMD_APPEND: begin
        if (!is_alpha(p)) r.status = ST_KEY_SKIP;
        else if (key_len >= KeyMax) r.status = ST_KEY_FULL;
        else begin
          key_mem[key_len] = pl_position(p);
          key_len++;
        end
      end
      CMD_RESTART: key_ptr = 0;
      default: begin
        if (!is_alpha(p)) r.status = ST_MSG_SKIP;
        else if (key_len == 0) r.status = ST_NO_KEY;
        else begin
          len = polish_sel ? AlphaPl : AlphaLt;
          mc  = pl_position(p);
          if (key_ptr >= key_len) key_ptr = 0;
          kc = key_mem[key_ptr];
          if (polish_sel) begin
            m = (mc < AlphaPl) ? mc : 0;
            k = (kc < AlphaPl) ? kc : 0;
          end else begin
            m = (mc < AlphaPl) ? PLAIN_OF[mc] : 0;
            k = (kc < AlphaPl && !ACCENTED[kc]) ? PLAIN_OF[kc] : 0;
          end
          idx = encrypt_sel ? (m + k) % len : (m + len - k) % len;
          r.code   = cp_t'(polish_sel ? POLISH_CP[idx] : 'h41 + idx);
          r.status = ST_LETTER;
          key_ptr++;
          if (key_ptr >= key_len) key_ptr = 0;
        end
      end
    endcase
    return r;
  endfunction

  // predict on accepted inputs, check accepted outputs, follow register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPolish) polish_sel = cfg_data_i;
        else encrypt_sel = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = cipher_step(cmd_e'(s_axis_tuser), s_axis_tdata[8:0]);
        if (given_typed) begin
          pred.status = given_status;
          pred.code   = given_code;
        end
        cipher_q = {cipher_q, pred};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser < 6) seen_by_status[m_axis_tuser]++;
        if (cipher_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result: status %0d data %04h", m_axis_tuser, m_axis_tdata);
        end else begin
          head = cipher_q.pop_front();
          if (m_axis_tuser !== head.status || m_axis_tdata !== {7'd0, head.code}) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch at result %0d: expected %0d/%03h, got %0d/%04h",
                       results_seen, head.status, head.code, m_axis_tuser, m_axis_tdata);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_len != 0) begin
      m_axis_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic offer(cmd_e c, cp_t p, logic typed = 1'b0, status_e st = ST_LETTER,
                       cp_t code = '0);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {7'd0, p};
    given_typed   <= typed;
    given_status  <= st;
    given_code    <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cp_t any_letter();
    int unsigned r;
    cp_t c;
    r = $urandom_range(0, 9);
    if (r < 4) c = cp_t'(($urandom_range(0, 1) ? 'h61 : 'h41) + $urandom_range(0, 25));
    else if (r < 7) begin
      c = cp_t'(POLISH_CP[$urandom_range(0, AlphaPl - 1)]);
      if ($urandom_range(0, 1)) c = (c >= 'h100) ? c + cp_t'(1) : c + cp_t'('h20);
    end else c = cp_t'($urandom_range('h0C0, 'h17F));
    return c;
  endfunction

  function automatic cp_t mostly_letter(int unsigned noise_pct);
    if ($urandom_range(0, 99) < noise_pct) return cp_t'($urandom_range(0, 511));
    return any_letter();
  endfunction

  // one key load followed by a message; some are plain noise
  task automatic send_phrase(bit long_key);
    int unsigned pick, nkey;
    pick = $urandom_range(0, 99);
    if (!long_key && pick < 10) begin
      repeat ($urandom_range(1, 6))
        offer(cmd_e'($urandom_range(0, 3)), cp_t'($urandom_range(0, 511)));
    end else begin
      if (long_key || pick >= 25) offer(CMD_CLEAR, cp_t'($urandom_range(0, 511)));
      if (long_key) nkey = 70;
      else if ($urandom_range(0, 9) == 0) nkey = $urandom_range(9, 40);
      else nkey = $urandom_range(1, 6);
      repeat (nkey) offer(CMD_APPEND, mostly_letter(8));
      if ($urandom_range(0, 3) == 0) offer(CMD_RESTART, cp_t'($urandom_range(0, 511)));
      repeat ($urandom_range(1, 16)) offer(CMD_MESSAGE, mostly_letter(15));
    end
  endtask

  initial begin
    int unsigned phase_end;
    polish_sel  = 1'b0;
    encrypt_sel = 1'b1;
    key_len     = 0;
    key_ptr     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      offer(DIRECTED[i].cmd, DIRECTED[i].cp, DIRECTED[i].typed, DIRECTED[i].status,
            DIRECTED[i].code);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgPolish;
      cfg_data_i  <= PHASE_CFG[ph][1];
      @(posedge clk_i);
      cfg_index_i <= CfgEncrypt;
      cfg_data_i  <= PHASE_CFG[ph][0];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 60; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 60; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      if (ph == 0) begin
        // output held off while a long key streams in: fills the pipe, stalls input
        hold_len <= 250;
        send_phrase(1'b1);
        drain();
      end else if (ph == 2) begin
        send_phrase(1'b1);
      end
      phase_end = items_sent + 125;
      while (items_sent < phase_end) send_phrase(1'b0);
    end

    drain();
    repeat (8) @(posedge clk_i);
    bad_count += cipher_q.size();
    $display("%0d items sent, %0d results checked over 6 alphabet/direction settings",
             items_sent, results_seen);
    $display("letters %0d, message skips %0d, no key %0d, done %0d, key skips %0d, key full %0d",
             seen_by_status[ST_LETTER], seen_by_status[ST_MSG_SKIP], seen_by_status[ST_NO_KEY],
             seen_by_status[ST_DONE], seen_by_status[ST_KEY_SKIP], seen_by_status[ST_KEY_FULL]);
    if (bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
